// ----- rtl/rlti_pkg.sv -----
// Shared types and constants for the radix literal to integer converter.
// No dependencies; imported by every module of the block.
package rlti_pkg;

  // One input transfer: a character of the literal and its end mark.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BASE  = 2'd1,
    ST_BAD_DIGIT = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  // One result transfer.
  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } result_t;

  // Classified character, front to back.
  typedef struct packed {
    logic       is_hash;
    logic       is_dec;    // 0-9
    logic       is_digit;  // 0-9, a-z, A-Z
    logic [5:0] digit;     // 0..35 when is_digit
    logic       last;
  } class_t;

  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [5:0] BASE_MIN  = 6'd2;
  localparam logic [5:0] BASE_MAX  = 6'd36;
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

endpackage

// ----- rtl/rlti_front.sv -----
// Front end: accepts characters, classifies them, and holds them in a
// two-entry queue for the back end. Depends on rlti_pkg.
module rlti_front
  import rlti_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  item_t  item,
  input  logic   push,
  output logic   full,
  output class_t head,
  output logic   head_valid,
  input  logic   take
);

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7a;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5a;
  localparam logic [7:0] TEN     = 8'd10;

  class_t     cls;
  class_t     q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  always_comb begin
    cls          = '0;
    cls.is_hash  = (item.char_code == CHAR_HASH);
    cls.last     = item.last_char;
    if (item.char_code >= CHAR_0 && item.char_code <= CHAR_9) begin
      cls.is_dec   = 1'b1;
      cls.is_digit = 1'b1;
      cls.digit    = 6'(item.char_code - CHAR_0);
    end else if (item.char_code >= CHAR_LA && item.char_code <= CHAR_LZ) begin
      cls.is_digit = 1'b1;
      cls.digit    = 6'(item.char_code - CHAR_LA + TEN);
    end else if (item.char_code >= CHAR_UA && item.char_code <= CHAR_UZ) begin
      cls.is_digit = 1'b1;
      cls.digit    = 6'(item.char_code - CHAR_UA + TEN);
    end
  end

  assign full       = (count == QUEUE_DEPTH);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];
  assign wr         = push && !full;
  assign rd         = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= cls;
    end
  end

endmodule

// ----- rtl/rlti_back.sv -----
// Back end: base and digit accumulation, error tracking, and a two-entry
// result queue. Depends on rlti_pkg.
module rlti_back
  import rlti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  class_t      head,
  input  logic        head_valid,
  output logic        take,
  input  logic [63:0] max_value,
  output result_t     result,
  output logic        empty,
  input  logic        pop
);

  localparam logic [8:0] DEC_RADIX = 9'd10;

  logic        in_digit, in_digit_next;
  logic [5:0]  base, base_next;
  logic [63:0] acc, acc_next;
  status_t     err, err_next;

  logic [8:0]  dec_acc;
  logic [69:0] mac;
  logic        base_good;
  status_t     st;
  result_t     res;
  logic        res_push;

  result_t     oq [2];
  logic        owr_ptr;
  logic        ord_ptr;
  logic [1:0]  ocount;
  logic        ofull;
  logic        ord;

  assign ofull = (ocount == QUEUE_DEPTH);
  assign empty = (ocount == 2'd0);
  assign take  = head_valid && (!head.last || !ofull);
  assign ord   = pop && !empty;

  assign dec_acc = {3'd0, base} * DEC_RADIX + {3'd0, head.digit};
  // Exact next running value; compared against the limit before committing
  assign mac = {6'd0, acc} * {64'd0, base} + {64'd0, head.digit};

  always_comb begin
    in_digit_next = in_digit;
    base_next     = base;
    acc_next      = acc;
    err_next      = err;
    st            = ST_OK;
    res           = '0;
    res_push      = 1'b0;
    base_good     = 1'b0;
    if (take) begin
      if (!in_digit) begin
        if (head.is_hash) begin
          in_digit_next = 1'b1;
          if (base < BASE_MIN || base > BASE_MAX) begin
            err_next = ST_BAD_BASE;
          end
        end else if (err != ST_BAD_BASE) begin
          if (!head.is_dec || dec_acc > {3'd0, BASE_MAX}) begin
            err_next = ST_BAD_BASE;
          end else begin
            base_next = dec_acc[5:0];
          end
        end
      end else if (err != ST_BAD_BASE) begin
        if (!head.is_digit || head.digit >= base) begin
          err_next = ST_BAD_DIGIT;
        end else if (err == ST_OK) begin
          if (mac > {6'd0, max_value}) begin
            err_next = ST_TOO_LARGE;
          end else begin
            acc_next = mac[63:0];
          end
        end
      end

      if (head.last) begin
        base_good = (base_next >= BASE_MIN) && (base_next <= BASE_MAX);
        st = err_next;
        if (!in_digit_next && st == ST_OK && !base_good) begin
          st = ST_BAD_BASE;
        end
        res.status    = st;
        res.value     = (st == ST_OK) ? acc_next : 64'd0;
        res_push      = 1'b1;
        in_digit_next = 1'b0;
        base_next     = 6'd0;
        acc_next      = 64'd0;
        err_next      = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_digit <= 1'b0;
      base     <= 6'd0;
      acc      <= 64'd0;
      err      <= ST_OK;
    end else begin
      in_digit <= in_digit_next;
      base     <= base_next;
      acc      <= acc_next;
      err      <= err_next;
    end
  end

  // result queue
  assign result = oq[ord_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocount  <= 2'd0;
    end else begin
      if (res_push) begin
        owr_ptr <= ~owr_ptr;
      end
      if (ord) begin
        ord_ptr <= ~ord_ptr;
      end
      ocount <= ocount + {1'b0, res_push} - {1'b0, ord};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[owr_ptr] <= res;
    end
  end

endmodule

// ----- rtl/radix_literal_to_integer.sv -----
// Top level of the radix literal to integer converter.
// Depends on rlti_pkg, rlti_front and rlti_back.
//
// Usage:
//  - Input channel (push/full): one character of a literal "base#digits" per
//    transfer, with last_char set on the final character. A transfer happens
//    when push is high and full is low.
//  - Result channel (empty/pop): one result per literal, produced by its last
//    character. The oldest result sits on 'result' while empty is low; it is
//    taken when pop is high and empty is low.
//  - Config channel (cfg_valid/cfg_ready): writes max_value; cfg_ready is
//    always high. Write only while no literal is in flight.
//  - Throughput: one character per cycle, sustained while the result queue
//    has room; a last character is held while it is full. The back end does
//    one multiply-accumulate by the base (up to 36) and one 70-bit compare
//    per character, which sets the cycle time.
//  - Path: front queue, then the back end writes the result queue.
//  - Stall: if the receiver stops popping, the two-entry result queue fills,
//    the back end holds the next last character, the front queue fills and
//    full rises. Nothing is dropped.
//  - Reset: both queues empty, parser returns to reading the base, and
//    max_value is set to all ones.
module radix_literal_to_integer
  import rlti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        push,
  output logic        full,
  output result_t     result,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic [63:0] max_value;
  class_t      head;
  logic        head_valid;
  logic        take;

  // configuration register, writable at any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= '1;
    end else if (cfg_valid && cfg_ready) begin
      max_value <= cfg_data;
    end
  end

  // front end: classify and queue characters
  rlti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push       (push),
    .full       (full),
    .head       (head),
    .head_valid (head_valid),
    .take       (take)
  );

  // back end: accumulate, check, queue results
  rlti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .take       (take),
    .max_value  (max_value),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  // queues come out of reset empty
  assert property (@(posedge clk) $fell(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

  // back end only takes a transfer that is present
  assert property (@(posedge clk) disable iff (rst) take |-> head_valid)
    else $error("back end took from an empty front queue");

  // an error result always carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status == ST_OK || result.value == 64'd0))
    else $error("error result with non-zero value");

  // config writes keep max_value as written
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (max_value == $past(cfg_data)))
    else $error("max_value not updated by config write");

endmodule
